@@ hw/rtl/iq_sample_frame_deframer_defines.svh @@
// Assertion macros used by the deframer core (dfr_core).
`ifndef IQ_SAMPLE_FRAME_DEFRAMER_DEFINES_SVH
`define IQ_SAMPLE_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DFR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, checked out of reset.
`define DFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

@@ hw/rtl/dfr_pkg.sv @@
// Types and constants for the IQ sample frame deframer.
package dfr_pkg;

    localparam int          PAYLOAD_DEPTH = 6;
    localparam logic [2:0]  PAYLOAD_LEN   = 3'd6;
    localparam logic [2:0]  CSUM_POS      = 3'd7;
    localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
    localparam logic [15:0] IDLE_MAX      = 16'hFFFF;
    localparam logic [3:0]  NIB_MASK      = 4'hF;

    typedef enum logic {
        KIND_BYTE = 1'b0,
        KIND_TICK = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_SUM = 2'd1,
        ST_TIMEOUT = 2'd2
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [11:0] i1_sample;
        logic [11:0] q1_sample;
        logic [11:0] i2_sample;
        logic [11:0] q2_sample;
        logic [2:0]  bytes_seen;
    } t_result;

endpackage

@@ hw/rtl/dfr_core.sv @@
// Frame assembly, checksum and idle timeout for one buffered beat.
module dfr_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_advance,
    input  dfr_pkg::t_kind    i_kind,
    input  logic [7:0]        i_rx_byte,
    input  logic [15:0]       i_timeout_ticks,
    output logic              o_has_result,
    output dfr_pkg::t_result  o_result
);
    import dfr_pkg::*;
    `include "iq_sample_frame_deframer_defines.svh"

    logic [2:0]  r_pos, n_pos;
    logic [7:0]  r_sum, n_sum;
    logic [15:0] r_idle, n_idle;
    logic        r_reported, n_reported;
    logic [7:0]  r_payload [PAYLOAD_DEPTH];
    logic        w_store;
    logic [15:0] w_idle_inc;

    assign w_idle_inc = (r_idle == IDLE_MAX) ? r_idle : r_idle + 16'd1;

    always_comb begin
        n_pos        = r_pos;
        n_sum        = r_sum;
        n_idle       = r_idle;
        n_reported   = r_reported;
        w_store      = 1'b0;
        o_has_result = 1'b0;
        o_result     = '0;
        if (i_valid) begin
            case (i_kind)
                KIND_BYTE: begin
                    n_idle     = '0;
                    n_reported = 1'b0;
                    if (r_pos != CSUM_POS) begin
                        w_store = (r_pos < PAYLOAD_LEN);
                        n_sum   = r_sum + i_rx_byte;
                        n_pos   = r_pos + 3'd1;
                    end else begin
                        o_has_result        = 1'b1;
                        o_result.status     = (i_rx_byte == r_sum) ? ST_OK : ST_BAD_SUM;
                        o_result.i1_sample  = {r_payload[0], r_payload[1][7:4]};
                        o_result.q1_sample  = {r_payload[1][3:0] & NIB_MASK, r_payload[2]};
                        o_result.i2_sample  = {r_payload[3], r_payload[4][7:4]};
                        o_result.q2_sample  = {r_payload[4][3:0] & NIB_MASK, r_payload[5]};
                        o_result.bytes_seen = 3'd0;
                        n_pos = '0;
                        n_sum = '0;
                    end
                end
                KIND_TICK: begin
                    if (!r_reported) begin
                        if (w_idle_inc >= i_timeout_ticks) begin
                            // report once, then restart the frame
                            o_has_result        = 1'b1;
                            o_result.status     = ST_TIMEOUT;
                            o_result.bytes_seen = r_pos;
                            n_pos      = '0;
                            n_sum      = '0;
                            n_idle     = '0;
                            n_reported = 1'b1;
                        end else begin
                            n_idle = w_idle_inc;
                        end
                    end
                end
                default: begin
                    n_pos = r_pos;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_sum      <= '0;
            r_idle     <= '0;
            r_reported <= 1'b0;
        end else if (i_advance) begin
            r_pos      <= n_pos;
            r_sum      <= n_sum;
            r_idle     <= n_idle;
            r_reported <= n_reported;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && w_store) begin
            r_payload[r_pos] <= i_rx_byte;
        end
    end

    `DFR_ASSERT_NEXT(a_timeout_restarts, i_clk, i_rst_n,
        i_advance && o_has_result && o_result.status == ST_TIMEOUT,
        r_pos == 3'd0 && r_sum == 8'd0 && r_reported)
    `DFR_ASSERT_NOW(a_reported_idle_clear, i_clk, i_rst_n, r_reported, r_idle == 16'd0)
    `DFR_ASSERT_NEXT(a_byte_clears_report, i_clk, i_rst_n,
        i_advance && i_valid && i_kind == KIND_BYTE, !r_reported && r_idle == 16'd0)

endmodule

@@ hw/rtl/dfr_out_reg.sv @@
// Result register driving the master-side stream.
module dfr_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  dfr_pkg::t_result  i_result,
    input  logic              i_m_tready,
    output logic              o_m_tvalid,
    output logic [1:0]        o_m_tuser,
    output logic [55:0]       o_m_tdata,
    output logic              o_free
);
    import dfr_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free     = !r_valid || i_m_tready;
    assign o_m_tvalid = r_valid;
    assign o_m_tuser  = r_result.status;
    assign o_m_tdata  = {5'd0, r_result.bytes_seen, r_result.q2_sample, r_result.i2_sample,
                         r_result.q1_sample, r_result.i1_sample};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_load || (r_valid && !i_m_tready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

@@ hw/rtl/iq_sample_frame_deframer.sv @@
// Top level of the IQ sample frame deframer.
// Input stream: one beat per received byte or time tick. s_axis_tuser is the
// kind (0 byte, 1 tick), s_axis_tdata the byte. Bytes gather into 8-byte frames:
// six bytes of four 12-bit big-endian samples (I1, Q1, I2, Q2), one pad byte and
// a modulo-256 checksum byte. The checksum byte gives one result beat with
// status ok or bad sum. After timeout_ticks idle ticks since the last byte one
// timeout beat is given, carrying the bytes collected, and the frame restarts.
// Output stream: m_axis_tuser is the status, m_axis_tdata the samples and count.
// Config: a write on i_cfg_valid sets timeout_ticks; o_cfg_ready is always high.
// A beat taken waits in the input register and is processed from there; a
// result is loaded into the result register and valid on m_axis from then on.
// One beat per cycle is sustained while m_axis_tready is high: the input and
// result registers each hold one beat. Reset empties both registers, restarts
// the frame and sets timeout_ticks to 5000. When the receiver stalls, the
// result register holds its beat, the input register keeps one more, and
// s_axis_tready drops only while a beat that yields a result waits there.
module iq_sample_frame_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [11:0] i1, [23:12] q1, [35:24] i2,
                                        // [47:36] q2, [50:48] bytes_seen, rest 0
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    import dfr_pkg::*;

    logic        r_in_valid;
    t_kind       r_in_kind;
    logic [7:0]  r_in_byte;
    logic [15:0] r_timeout_ticks;
    logic        w_advance;
    logic        w_has_result;
    logic        w_out_free;
    t_result     w_result;

    assign o_cfg_ready   = 1'b1;
    // advance the buffered beat unless its result has nowhere to go
    assign w_advance     = r_in_valid && (!w_has_result || w_out_free);
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_timeout_ticks <= TIMEOUT_RESET;
        end else begin
            r_in_valid <= (s_axis_tvalid && s_axis_tready) || (r_in_valid && !w_advance);
            if (i_cfg_valid) begin
                r_timeout_ticks <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_kind <= t_kind'(s_axis_tuser);
            r_in_byte <= s_axis_tdata;
        end
    end

    dfr_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (r_in_valid),
        .i_advance       (w_advance),
        .i_kind          (r_in_kind),
        .i_rx_byte       (r_in_byte),
        .i_timeout_ticks (r_timeout_ticks),
        .o_has_result    (w_has_result),
        .o_result        (w_result)
    );

    dfr_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_advance && w_has_result),
        .i_result   (w_result),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tuser  (m_axis_tuser),
        .o_m_tdata  (m_axis_tdata),
        .o_free     (w_out_free)
    );

endmodule
